[design/b64d_pkg.sv]
package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR    = 3'd2;
	localparam logic [2:0] ST_RESERVED    = 3'd3;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
	localparam logic [2:0] ST_BASE58      = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_Q     = 8'h51;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_Z     = 8'h7a;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] byte_value;
		logic [2:0] status;
		logic       run_end;
	} out_item_t;

	// one accepted character's worth of results: data bytes, then maybe a status
	typedef struct packed {
		logic [1:0]      n_bytes;
		logic [2:0][7:0] bytes;
		logic            has_status;
		logic [2:0]      status;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] sextet;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.valid  = 1'b1;
		r.sextet = 6'd0;
		if (c inside {[8'h41:8'h5a]}) begin
			r.sextet = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7a]}) begin
			r.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2d) begin
			r.sextet = 6'd62;
		end else if (c == 8'h5f) begin
			r.sextet = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

[design/b64d_front.sv]
module b64d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  b64d_pkg::in_item_t item,
	output logic               push,
	output b64d_pkg::job_t     job
);

	logic        awaiting_q;
	logic [1:0]  count_q;
	logic [17:0] group_q;
	logic [2:0]  error_q;

	logic        awaiting_n;
	logic [1:0]  count_n;
	logic [17:0] group_n;
	logic [2:0]  error_n;
	logic [23:0] full_group;
	logic [2:0]  st;
	b64d_pkg::sextet_t sx;

	always_comb begin
		sx         = b64d_pkg::sextet_of(item.char_code);
		awaiting_n = awaiting_q;
		count_n    = count_q;
		group_n    = group_q;
		error_n    = error_q;
		full_group = {group_q, sx.sextet};
		st         = b64d_pkg::ST_OK;
		job        = '0;

		if (awaiting_q) begin
			awaiting_n = 1'b0;
			count_n    = 2'd0;
			group_n    = '0;
			if (item.char_code == b64d_pkg::CH_U) begin
				error_n = b64d_pkg::ST_OK;
			end else if (item.char_code == b64d_pkg::CH_Z) begin
				error_n = b64d_pkg::ST_BASE58;
			end else if (item.char_code == b64d_pkg::CH_NUL ||
				item.char_code == b64d_pkg::CH_SLASH ||
				item.char_code == b64d_pkg::CH_ONE ||
				item.char_code == b64d_pkg::CH_Q) begin
				error_n = b64d_pkg::ST_RESERVED;
			end else begin
				error_n = b64d_pkg::ST_UNSUPPORTED;
			end
		end else if (error_q == b64d_pkg::ST_OK || error_q == b64d_pkg::ST_BAD_CHAR) begin
			if (!sx.valid) begin
				error_n = b64d_pkg::ST_BAD_CHAR;
			end
			if (count_q == 2'd3) begin
				if (error_n == b64d_pkg::ST_OK) begin
					job.n_bytes  = 2'd3;
					job.bytes[0] = full_group[23:16];
					job.bytes[1] = full_group[15:8];
					job.bytes[2] = full_group[7:0];
				end
				group_n = '0;
				count_n = 2'd0;
			end else begin
				group_n = {group_q[11:0], sx.sextet};
				count_n = count_q + 2'd1;
			end
		end

		if (item.last_char) begin
			st = error_n;
			if (st == b64d_pkg::ST_OK || st == b64d_pkg::ST_BAD_CHAR) begin
				if (count_n == 2'd1) begin
					st = b64d_pkg::ST_BAD_LENGTH;
				end else if (st == b64d_pkg::ST_OK) begin
					if (count_n == 2'd2) begin
						if (group_n[3:0] != 4'd0) begin
							st = b64d_pkg::ST_BAD_CHAR;
						end else begin
							job.n_bytes  = 2'd1;
							job.bytes[0] = group_n[11:4];
						end
					end else if (count_n == 2'd3) begin
						if (group_n[1:0] != 2'd0) begin
							st = b64d_pkg::ST_BAD_CHAR;
						end else begin
							job.n_bytes  = 2'd2;
							job.bytes[0] = group_n[17:10];
							job.bytes[1] = group_n[9:2];
						end
					end
				end
			end
			job.has_status = 1'b1;
			job.status     = st;
			// string done, back to expecting a prefix
			awaiting_n = 1'b1;
			count_n    = 2'd0;
			group_n    = '0;
			error_n    = b64d_pkg::ST_OK;
		end

		push = accept && (job.n_bytes != 2'd0 || job.has_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			count_q    <= 2'd0;
			group_q    <= '0;
			error_q    <= b64d_pkg::ST_OK;
		end else if (accept) begin
			awaiting_q <= awaiting_n;
			count_q    <= count_n;
			group_q    <= group_n;
			error_q    <= error_n;
		end
	end

endmodule

[design/b64d_queue.sv]
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output b64d_pkg::job_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::job_t         entries_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/b64d_back.sv]
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  b64d_pkg::job_t      q_head,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_stall,
	output b64d_pkg::out_item_t res_data
);

	b64d_pkg::job_t cur_q;
	logic           valid_q;
	logic [1:0]     idx_q;
	logic [2:0]     total;
	logic           fire;
	logic           done;

	always_comb begin
		total     = {1'b0, cur_q.n_bytes} + {2'b00, cur_q.has_status};
		res_valid = valid_q;
		res_data  = '0;
		if (idx_q < cur_q.n_bytes) begin
			res_data.byte_value = cur_q.bytes[idx_q];
		end else begin
			res_data.is_status = 1'b1;
			res_data.status    = cur_q.status;
		end
		res_data.run_end = ({1'b0, idx_q} == total - 3'd1);
		fire  = valid_q && !res_stall;
		done  = fire && res_data.run_end;
		q_pop = (!valid_q || done) && !q_empty;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

[design/base64url_stream_decoder.sv]
// channel | valid      | stall      | payload
// --------+------------+------------+-------------------------------------------
// input   | char_valid | char_stall | char_data: char_code, last_char
// output  | res_valid  | res_stall  | res_data: is_status, byte_value, status, run_end
//
// one character is taken per cycle while the job queue has room; char_stall is the
// queue-full flag. a character yields 0 to 4 results, sent one per cycle from the
// back end while res_stall is low.
// results of a character pass through the job queue and the back end's job register.
// arst_n clears prefix tracking, the queue and the output; no clearing pass.
// output stall backs up the queue only; the front keeps decoding until it is full.
module base64url_stream_decoder #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  b64d_pkg::in_item_t  char_data,
	output logic                res_valid,
	input  logic                res_stall,
	output b64d_pkg::out_item_t res_data
);

	// front to queue
	logic           push;
	b64d_pkg::job_t push_job;
	logic           accept;

	// queue to back
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	b64d_pkg::job_t q_head;

	// stall straight from the registered queue count
	assign char_stall = q_full;
	assign accept     = char_valid && !char_stall;

	// prefix check, sextet mapping and grouping, at most one job per character
	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (char_data),
		.push   (push),
		.job    (push_job)
	);

	// short job queue decouples decode from result delivery
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// serializes each job into bytes then status, one result per transaction
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

[bench/tb_base64url_stream_decoder.sv]
`timescale 1ns / 100ps

module tb_base64url_stream_decoder;

	// one queued character plus whether the sender first waits for the block to drain
	typedef struct {
		b64d_pkg::in_item_t item;
		bit                 drain_first;
	} queued_char_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	b64d_pkg::in_item_t  char_data  = '0;
	logic                res_valid;
	logic                res_stall  = 1'b0;
	b64d_pkg::out_item_t res_data;

	queued_char_t        queued_chars[$];
	b64d_pkg::out_item_t decoded_due[$];

	// decoder state as seen by the predictor
	bit         want_prefix  = 1'b1;
	logic [1:0] sextets_held = 2'd0;
	logic [17:0] group_acc   = 18'd0;
	logic [2:0] string_err   = b64d_pkg::ST_OK;

	int unsigned chars_sent    = 0;  // nonblocking, read by the hold-off process
	int unsigned results_taken = 0;  // nonblocking, read by the sender
	int unsigned results_owed  = 0;  // sender only
	int unsigned send_wait     = 0;
	int unsigned recv_wait     = 0;
	int unsigned hold_left     = 0;
	bit          hold_started  = 1'b0;
	int unsigned mismatch_count = 0;

	base64url_stream_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// base64url alphabet lookup; invalid characters give sextet 0
	function automatic bit sextet_lookup(input logic [7:0] ch, output logic [5:0] sx);
		sx = 6'd0;
		if (ch >= 8'h41 && ch <= 8'h5a) begin         // A-Z
			sx = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin  // a-z
			sx = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin  // 0-9
			sx = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2d) begin                 // '-'
			sx = 6'd62;
		end else if (ch == 8'h5f) begin                 // '_'
			sx = 6'd63;
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] alphabet_char(input logic [5:0] sx);
		if (sx < 6'd26) return 8'h41 + 8'(sx);
		if (sx < 6'd52) return 8'h61 + 8'(sx - 6'd26);
		if (sx < 6'd62) return 8'h30 + 8'(sx - 6'd52);
		if (sx == 6'd62) return 8'h2d;
		return 8'h5f;
	endfunction

	function automatic b64d_pkg::out_item_t data_result(input logic [7:0] b);
		b64d_pkg::out_item_t r;
		r = '0;
		r.byte_value = b;
		r.status     = b64d_pkg::ST_OK;
		return r;
	endfunction

	// advance the decoder state by one character and queue the results it yields
	task automatic decode_char(input b64d_pkg::in_item_t it, output int unsigned n);
		b64d_pkg::out_item_t batch[4];
		logic [5:0] sx;
		logic [23:0] grp;
		logic [2:0] st;
		bit         is_sym;
		n = 0;
		if (want_prefix) begin
			want_prefix  = 1'b0;
			sextets_held = 2'd0;
			group_acc    = 18'd0;
			case (it.char_code)
				b64d_pkg::CH_U:     string_err = b64d_pkg::ST_OK;
				b64d_pkg::CH_Z:     string_err = b64d_pkg::ST_BASE58;
				b64d_pkg::CH_NUL, b64d_pkg::CH_SLASH, b64d_pkg::CH_ONE, b64d_pkg::CH_Q:
				                    string_err = b64d_pkg::ST_RESERVED;
				default:            string_err = b64d_pkg::ST_UNSUPPORTED;
			endcase
		end else if (string_err == b64d_pkg::ST_OK || string_err == b64d_pkg::ST_BAD_CHAR) begin
			is_sym = sextet_lookup(it.char_code, sx);
			if (!is_sym) string_err = b64d_pkg::ST_BAD_CHAR;
			if (sextets_held == 2'd3) begin
				grp = {group_acc, sx};
				// an error anywhere so far suppresses data
				if (string_err == b64d_pkg::ST_OK) begin
					batch[n++] = data_result(grp[23:16]);
					batch[n++] = data_result(grp[15:8]);
					batch[n++] = data_result(grp[7:0]);
				end
				group_acc    = 18'd0;
				sextets_held = 2'd0;
			end else begin
				group_acc    = {group_acc[11:0], sx};
				sextets_held = sextets_held + 2'd1;
			end
		end
		if (it.last_char) begin
			st = string_err;
			if (st == b64d_pkg::ST_OK || st == b64d_pkg::ST_BAD_CHAR) begin
				if (sextets_held == 2'd1) begin
					st = b64d_pkg::ST_BAD_LENGTH;
				end else if (st == b64d_pkg::ST_OK && sextets_held == 2'd2) begin
					if (group_acc[3:0] != 4'd0) st = b64d_pkg::ST_BAD_CHAR;
					else batch[n++] = data_result(group_acc[11:4]);
				end else if (st == b64d_pkg::ST_OK && sextets_held == 2'd3) begin
					if (group_acc[1:0] != 2'd0) st = b64d_pkg::ST_BAD_CHAR;
					else begin
						batch[n++] = data_result(group_acc[17:10]);
						batch[n++] = data_result(group_acc[9:2]);
					end
				end
			end
			batch[n] = '0;
			batch[n].is_status = 1'b1;
			batch[n].status    = st;
			n++;
			want_prefix  = 1'b1;
			sextets_held = 2'd0;
			group_acc    = 18'd0;
			string_err   = b64d_pkg::ST_OK;
		end
		if (n != 0) batch[n - 1].run_end = 1'b1;
		for (int i = 0; i < n; i++) decoded_due.push_back(batch[i]);
	endtask

	task automatic add_char(input logic [7:0] ch, input bit last, input bit drain_first);
		queued_char_t q;
		q.item.char_code = ch;
		q.item.last_char = last;
		q.drain_first    = drain_first;
		queued_chars.push_back(q);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	// mostly well-formed strings, plus broken ones, bad lengths and foreign prefixes
	task automatic add_random_string(input bit drain_first);
		int unsigned kind;
		int unsigned len;
		int unsigned bad_pos;
		logic [7:0]  prefix;
		logic [7:0]  ch;
		logic [5:0]  sx;
		kind    = $urandom_range(0, 9);
		prefix  = b64d_pkg::CH_U;
		bad_pos = 0;
		if (kind <= 6) begin
			len = $urandom_range(0, 11);
			if (len % 4 == 1) len++;
		end else if (kind == 7) begin
			len     = $urandom_range(1, 10);
			bad_pos = $urandom_range(1, len);
		end else if (kind == 8) begin
			len = 4 * $urandom_range(0, 2) + 1;
		end else begin
			len = $urandom_range(0, 4);
			case ($urandom_range(0, 5))
				0:       prefix = b64d_pkg::CH_NUL;
				1:       prefix = b64d_pkg::CH_SLASH;
				2:       prefix = b64d_pkg::CH_ONE;
				3:       prefix = b64d_pkg::CH_Q;
				4:       prefix = b64d_pkg::CH_Z;
				default: prefix = 8'($urandom_range(0, 255));
			endcase
		end
		add_char(prefix, len == 0, drain_first);
		for (int i = 1; i <= len; i++) begin
			sx = 6'($urandom_range(0, 63));
			// clear leftover tail bits most of the time so the tail bytes come out
			if (kind <= 6 && i == len && $urandom_range(0, 3) != 0) begin
				if (len % 4 == 2) sx[3:0] = 4'd0;
				else if (len % 4 == 3) sx[1:0] = 2'd0;
			end
			ch = alphabet_char(sx);
			if (i == bad_pos || kind == 9 || (kind == 8 && $urandom_range(0, 7) == 0)) begin
				ch = 8'($urandom_range(0, 255));
			end
			add_char(ch, i == len, 1'b0);
		end
	endtask

	// sender: one transaction at a time, random gap drawn after each acceptance
	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		bit          busy;
		queued_char_t q;
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_data  <= '0;
			send_wait   = 0;
		end else begin
			busy = char_valid;
			if (char_valid && !char_stall) begin
				decode_char(char_data, n);
				results_owed = results_owed + n;
				chars_sent  <= chars_sent + 1;
				// every other run of 64 characters goes without gaps
				send_wait = chars_sent[6] ? 0 : $urandom_range(0, 7);
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_wait != 0) begin
					send_wait--;
					char_valid <= 1'b0;
				end else if (queued_chars.size() != 0 &&
				             !(queued_chars[0].drain_first && results_taken != results_owed)) begin
					q = queued_chars.pop_front();
					char_data  <= q.item;
					char_valid <= 1'b1;
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// one long output hold-off once the stream is well under way; the sender keeps
	// offering meanwhile so the job queue fills and char_stall rises
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			hold_started <= 1'b0;
		end else if (!hold_started && chars_sent >= 200) begin
			hold_left    <= 96;
			hold_started <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: check each result transaction, then stall for a random count
	always @(posedge clk or negedge arst_n) begin
		b64d_pkg::out_item_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_wait  = 0;
		end else begin
			if (res_valid && !res_stall) begin
				results_taken <= results_taken + 1;
				if (decoded_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", res_data));
				end else begin
					want = decoded_due.pop_front();
					if (res_data.is_status !== want.is_status ||
					    res_data.byte_value !== want.byte_value ||
					    res_data.status !== want.status ||
					    res_data.run_end !== want.run_end) begin
						report_mismatch($sformatf("got %p, expected %p", res_data, want));
					end
				end
				recv_wait = results_taken[5] ? 0 : $urandom_range(0, 7);
			end
			res_stall <= (hold_left != 0) || (recv_wait != 0);
			if (recv_wait != 0) recv_wait--;
		end
	end

	initial begin
		// prefix handling: base64url alone, each reserved code, base58, unsupported
		add_text("u");
		add_char(b64d_pkg::CH_NUL, 1'b1, 1'b0);
		add_text("/A");
		add_text("1");
		add_text("Q");
		add_text("zx");
		add_char(8'hff, 1'b1, 1'b0);
		// full group using the punctuation and digit ends of the alphabet
		add_text("u-_09");
		// two-sextet tail with clean leftover bits
		add_text("uAQ");
		// one sextet left over: bad length
		add_text("uA");
		// non-zero leftover bits
		add_text("uAB");
		// invalid character in the payload
		add_text("u*A");
		for (int s = 0; queued_chars.size() < 480; s++) add_random_string(s % 60 == 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_chars.size() != 0 || char_valid) @(posedge clk);
		while (decoded_due.size() != 0) @(posedge clk);
		// keep running to catch stray results
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_base64url_stream_decoder: PASS");
		end else begin
			$display("tb_base64url_stream_decoder: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_base64url_stream_decoder: FAIL");
		$finish;
	end

endmodule
